/* design/arm64_subset_instruction_decoder_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros used by the decoder top-level RTL
// ----------------------------------------------------------------------------
`ifndef ARM64_SUBSET_INSTRUCTION_DECODER_DEFINES_SVH
`define ARM64_SUBSET_INSTRUCTION_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define A64D_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("decoder check failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define A64D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("decoder check failed: next-cycle implication");

`endif

/* design/a64dec_pkg.sv */
// ----------------------------------------------------------------------------
// a64dec_pkg
// Types and codes for the A64 subset instruction decoder.
// ----------------------------------------------------------------------------
package a64dec_pkg;

  // Operand A select
  localparam logic [2:0] A_ZERO   = 3'd0;
  localparam logic [2:0] A_INT64  = 3'd1;
  localparam logic [2:0] A_INT32  = 3'd2;
  localparam logic [2:0] A_SP     = 3'd3;
  localparam logic [2:0] A_PC     = 3'd4;
  localparam logic [2:0] A_FP32   = 3'd5;

  // Operand B select
  localparam logic [1:0] B_IMM    = 2'd0;
  localparam logic [1:0] B_SHIFT  = 2'd1;
  localparam logic [1:0] B_REGX4  = 2'd2;
  localparam logic [1:0] B_FP32   = 2'd3;

  // ALU operations
  localparam logic [2:0] ALU_ADD  = 3'd0;
  localparam logic [2:0] ALU_SUBS = 3'd1;
  localparam logic [2:0] ALU_FADD = 3'd2;
  localparam logic [2:0] ALU_FSUB = 3'd3;
  localparam logic [2:0] ALU_FMUL = 3'd4;
  localparam logic [2:0] ALU_FDIV = 3'd5;

  // Memory operations
  localparam logic [2:0] MEM_IDLE   = 3'd0;
  localparam logic [2:0] MEM_RD32   = 3'd1;
  localparam logic [2:0] MEM_WR32   = 3'd2;
  localparam logic [2:0] MEM_RD32S  = 3'd4;

  // Write-back target
  localparam logic [2:0] DEST_NONE = 3'd0;
  localparam logic [2:0] DEST_INT  = 3'd1;
  localparam logic [2:0] DEST_SP   = 3'd2;
  localparam logic [2:0] DEST_PC   = 3'd3;
  localparam logic [2:0] DEST_FP   = 3'd4;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_UNIMP = 1'b1;

  localparam logic [4:0] REG_ZR_SP = 5'd31;
  localparam logic [3:0] COND_LE   = 4'hD;
  localparam logic [1:0] SHIFT_RSVD = 2'd3;

  // Major group codes, instr[28:25]
  localparam logic [3:0] GRP_DP_IMM_A = 4'h8;
  localparam logic [3:0] GRP_DP_IMM_B = 4'h9;
  localparam logic [3:0] GRP_DP_REG_A = 4'h5;
  localparam logic [3:0] GRP_DP_REG_B = 4'hD;
  localparam logic [3:0] GRP_FP_A     = 4'hF;
  localparam logic [3:0] GRP_FP_B     = 4'h7;
  localparam logic [3:0] GRP_LS_A     = 4'h4;
  localparam logic [3:0] GRP_LS_B     = 4'h6;
  localparam logic [3:0] GRP_LS_C     = 4'hC;
  localparam logic [3:0] GRP_LS_D     = 4'hE;
  localparam logic [3:0] GRP_BR_A     = 4'hA;
  localparam logic [3:0] GRP_BR_B     = 4'hB;

  // Opcode match patterns
  localparam logic [31:0] TOP9_MASK     = 32'hFF80_0000;
  localparam logic [31:0] OP_SUB_IMM64  = 32'hD100_0000;
  localparam logic [31:0] OP_CMP_IMM32  = 32'h7100_0000;
  localparam logic [31:0] ADD_MASK      = 32'hFF20_0000;
  localparam logic [31:0] OP_ADD_SR32   = 32'h0B00_0000;
  localparam logic [31:0] FP2_MASK      = 32'hFF20_FC00;
  localparam logic [31:0] OP_FADD       = 32'h1E20_2800;
  localparam logic [31:0] OP_FSUB       = 32'h1E20_3800;
  localparam logic [31:0] OP_FMUL       = 32'h1E20_0800;
  localparam logic [31:0] OP_FDIV       = 32'h1E20_1800;
  localparam logic [31:0] FNEG_MASK     = 32'hFF3F_FC00;
  localparam logic [31:0] OP_FNEG       = 32'h1E21_4000;
  localparam logic [31:0] TOP10_MASK    = 32'hFFC0_0000;
  localparam logic [31:0] OP_LDRSW_UIMM = 32'hB980_0000;
  localparam logic [31:0] OP_LDR_UIMM   = 32'hB940_0000;
  localparam logic [31:0] OP_STR_UIMM   = 32'hB900_0000;
  localparam logic [31:0] LDRR_MASK     = 32'hFFE0_FC00;
  localparam logic [31:0] OP_LDR_REG    = 32'hB860_7800;
  localparam logic [31:0] B_MASK        = 32'hFC00_0000;
  localparam logic [31:0] OP_B          = 32'h1400_0000;
  localparam logic [31:0] BCOND_MASK    = 32'hFF00_0010;
  localparam logic [31:0] OP_BCOND      = 32'h5400_0000;
  localparam logic [31:0] RET_MASK      = 32'hFFFF_FC1F;
  localparam logic [31:0] OP_RET        = 32'hD65F_0000;

  typedef struct packed {
    logic [31:0] instr;
    logic        flag_n;
    logic        flag_z;
    logic        flag_v;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic [2:0]         a_sel;
    logic [4:0]         a_index;
    logic [1:0]         b_sel;
    logic [4:0]         b_index;
    logic signed [27:0] immediate;
    logic [1:0]         shift_kind;
    logic [5:0]         shift_amount;
    logic [2:0]         alu_op;
    logic [2:0]         mem_op;
    logic [2:0]         dest_sel;
    logic [4:0]         dest_index;
  } out_item_t;

endpackage

/* design/a64dec_core.sv */
// ----------------------------------------------------------------------------
// a64dec_core
// Combinational decode of one instruction word and flags into control fields.
// ----------------------------------------------------------------------------
module a64dec_core (
  input  a64dec_pkg::in_item_t  item,
  output a64dec_pkg::out_item_t res
);
  import a64dec_pkg::*;

  logic [31:0] ir;
  logic [3:0]  grp;
  logic [4:0]  rd;
  logic [4:0]  rn;
  logic [4:0]  rm;
  logic [11:0] imm12;
  logic        single;
  logic        bad;
  out_item_t   dec;

  assign ir     = item.instr;
  assign grp    = ir[28:25];
  assign rd     = ir[4:0];
  assign rn     = ir[9:5];
  assign rm     = ir[20:16];
  assign imm12  = ir[21:10];
  assign single = (ir[23:22] == 2'b00);

  always_comb begin
    dec = '0;
    bad = 1'b0;
    if (grp inside {GRP_DP_IMM_A, GRP_DP_IMM_B}) begin
      if ((ir & TOP9_MASK) == OP_SUB_IMM64) begin
        bad            = ir[22];
        dec.a_sel      = (rn == REG_ZR_SP) ? A_SP : A_INT64;
        dec.a_index    = rn;
        dec.immediate  = {16'b0, imm12};
        dec.alu_op     = ALU_SUBS;
        dec.dest_sel   = (rd == REG_ZR_SP) ? DEST_SP : DEST_INT;
        dec.dest_index = rd;
      end else if ((ir & TOP9_MASK) == OP_CMP_IMM32) begin
        dec.a_sel     = (rn == REG_ZR_SP) ? A_SP : A_INT32;
        dec.a_index   = rn;
        dec.immediate = ir[22] ? {4'b0, imm12, 12'b0} : {16'b0, imm12};
        dec.alu_op    = ALU_SUBS;
      end else begin
        bad = 1'b1;
      end
    end else if (grp inside {GRP_DP_REG_A, GRP_DP_REG_B}) begin
      // reserved shift type and shifts of 32 or more are not supported
      bad = ((ir & ADD_MASK) != OP_ADD_SR32) || (ir[23:22] == SHIFT_RSVD) || ir[15];
      dec.a_sel        = A_INT32;
      dec.a_index      = rn;
      dec.b_sel        = B_SHIFT;
      dec.b_index      = rm;
      dec.shift_kind   = ir[23:22];
      dec.shift_amount = ir[15:10];
      dec.alu_op       = ALU_ADD;
      dec.dest_sel     = DEST_INT;
      dec.dest_index   = rd;
    end else if (grp inside {GRP_FP_A, GRP_FP_B}) begin
      dec.a_sel      = A_FP32;
      dec.a_index    = rn;
      dec.b_sel      = B_FP32;
      dec.b_index    = rm;
      dec.dest_sel   = DEST_FP;
      dec.dest_index = rd;
      bad            = !single;
      if ((ir & FP2_MASK) == OP_FADD) begin
        dec.alu_op = ALU_FADD;
      end else if ((ir & FP2_MASK) == OP_FSUB) begin
        dec.alu_op = ALU_FSUB;
      end else if ((ir & FP2_MASK) == OP_FMUL) begin
        dec.alu_op = ALU_FMUL;
      end else if ((ir & FP2_MASK) == OP_FDIV) begin
        dec.alu_op = ALU_FDIV;
      end else if ((ir & FNEG_MASK) == OP_FNEG) begin
        // negate as zero minus the source
        dec.a_sel   = A_ZERO;
        dec.a_index = '0;
        dec.b_index = rn;
        dec.alu_op  = ALU_FSUB;
      end else begin
        bad = 1'b1;
      end
    end else if (grp inside {GRP_LS_A, GRP_LS_B, GRP_LS_C, GRP_LS_D}) begin
      dec.a_sel      = (rn == REG_ZR_SP) ? A_SP : A_INT64;
      dec.a_index    = rn;
      dec.dest_index = rd;
      if ((ir & TOP10_MASK) == OP_STR_UIMM) begin
        dec.immediate = {14'b0, imm12, 2'b0};
        dec.mem_op    = MEM_WR32;
      end else if ((ir & TOP10_MASK) == OP_LDR_UIMM) begin
        dec.immediate = {14'b0, imm12, 2'b0};
        dec.mem_op    = MEM_RD32;
        dec.dest_sel  = DEST_INT;
      end else if ((ir & TOP10_MASK) == OP_LDRSW_UIMM) begin
        dec.immediate = {14'b0, imm12, 2'b0};
        dec.mem_op    = MEM_RD32S;
        dec.dest_sel  = DEST_INT;
      end else if ((ir & LDRR_MASK) == OP_LDR_REG) begin
        dec.b_sel    = B_REGX4;
        dec.b_index  = rm;
        dec.mem_op   = MEM_RD32;
        dec.dest_sel = DEST_INT;
      end else begin
        bad = 1'b1;
      end
    end else if (grp inside {GRP_BR_A, GRP_BR_B}) begin
      if ((ir & B_MASK) == OP_B) begin
        dec.a_sel     = A_PC;
        dec.immediate = {ir[25:0], 2'b0};
        dec.dest_sel  = DEST_PC;
      end else if ((ir & BCOND_MASK) == OP_BCOND) begin
        bad           = (ir[3:0] != COND_LE);
        dec.a_sel     = A_PC;
        dec.immediate = {{7{ir[23]}}, ir[23:5], 2'b0};
        dec.dest_sel  = (item.flag_z || (item.flag_n != item.flag_v)) ? DEST_PC : DEST_NONE;
      end else if ((ir & RET_MASK) == OP_RET) begin
        dec.a_sel    = A_INT64;
        dec.a_index  = rn;
        dec.dest_sel = DEST_PC;
      end else begin
        bad = 1'b1;
      end
    end else begin
      bad = 1'b1;
    end

    if (bad) begin
      res        = '0;
      res.status = STATUS_UNIMP;
    end else begin
      res        = dec;
      res.status = STATUS_OK;
    end
  end

endmodule

/* design/arm64_subset_instruction_decoder.sv */
// ----------------------------------------------------------------------------
// arm64_subset_instruction_decoder
// Stages: input register then result register around one decode.
// Throughput: one instruction per cycle; a stage advances when the result
// register is empty or out_ready drains it.
// Reset: rst_n low (synchronous) empties both stages; the data registers are not reset.
// ----------------------------------------------------------------------------
`include "arm64_subset_instruction_decoder_defines.svh"

module arm64_subset_instruction_decoder (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  a64dec_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output a64dec_pkg::out_item_t out_data
);
  import a64dec_pkg::*;

  logic      s1_valid_r;
  logic      s1_valid_nxt;
  in_item_t  s1_data_r;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_data_r;
  out_item_t dec_res;
  logic      s1_adv;
  logic      unimp_zeroed;

  a64dec_core u_core (
    .item (s1_data_r),
    .res  (dec_res)
  );

  // result register free or draining this cycle
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt  = in_ready ? in_valid : s1_valid_r;
    out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_adv && s1_valid_r) begin
      out_data_r <= dec_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign unimp_zeroed = (out_data_r.a_sel == A_ZERO) && (out_data_r.immediate == '0) &&
                        (out_data_r.dest_sel == DEST_NONE) &&
                        (out_data_r.mem_op == MEM_IDLE);

  `A64D_ASSERT_NOW(a_hold_when_full, s1_valid_r && out_valid_r && !out_ready, !in_ready)
  `A64D_ASSERT_NEXT(a_load_stage1, in_valid && in_ready, s1_valid_r)
  `A64D_ASSERT_NEXT(a_move_result, s1_valid_r && s1_adv, out_valid_r)
  `A64D_ASSERT_NOW(a_unimp_clean, out_valid_r && (out_data_r.status == STATUS_UNIMP), unimp_zeroed)

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the A64 subset decoder. A short run of directed
// encodings is followed by random well-formed, corrupted and noise words, all
// under a series of sender idle and receiver stall mixes. Every accepted
// instruction is decoded by a local predictor and each result transaction is
// checked field by field against it in order.
// ----------------------------------------------------------------------------
module tb_top;
  import a64dec_pkg::*;

  localparam int RANDOM_PER_PHASE = 460;
  localparam int HOLD_AT_RESULT   = 100;
  localparam int HOLD_CYCLES      = 300;
  localparam int DRAIN_CYCLES     = 20;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  in_item_t  instr_q[$];
  out_item_t decoded_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int err_count      = 0;
  int result_count   = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;

  arm64_subset_instruction_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #4000000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Expected decode of one instruction word with the current flags.
  function automatic out_item_t predict_decode(in_item_t it);
    logic [31:0] ir;
    logic [4:0]  rd;
    logic [4:0]  rn;
    logic [4:0]  rm;
    logic [11:0] imm12;
    logic [18:0] off19;
    logic        single;
    logic        unimp;
    out_item_t   r;
    ir     = it.instr;
    rd     = ir[4:0];
    rn     = ir[9:5];
    rm     = ir[20:16];
    imm12  = ir[21:10];
    off19  = ir[23:5];
    single = (ir[23:22] == 2'b00);
    r      = '0;
    unimp  = 1'b0;
    case (ir[28:25])
      GRP_DP_IMM_A, GRP_DP_IMM_B: begin
        if ((ir & TOP9_MASK) == OP_SUB_IMM64 && !ir[22]) begin
          r.a_sel      = (rn == REG_ZR_SP) ? A_SP : A_INT64;
          r.a_index    = rn;
          r.immediate  = {16'd0, imm12};
          r.alu_op     = ALU_SUBS;
          r.dest_sel   = (rd == REG_ZR_SP) ? DEST_SP : DEST_INT;
          r.dest_index = rd;
        end else if ((ir & TOP9_MASK) == OP_CMP_IMM32) begin
          r.a_sel     = (rn == REG_ZR_SP) ? A_SP : A_INT32;
          r.a_index   = rn;
          r.immediate = ir[22] ? {4'd0, imm12, 12'd0} : {16'd0, imm12};
          r.alu_op    = ALU_SUBS;
        end else begin
          unimp = 1'b1;
        end
      end
      GRP_DP_REG_A, GRP_DP_REG_B: begin
        if ((ir & ADD_MASK) == OP_ADD_SR32 && ir[23:22] != SHIFT_RSVD && !ir[15]) begin
          r.a_sel        = A_INT32;
          r.a_index      = rn;
          r.b_sel        = B_SHIFT;
          r.b_index      = rm;
          r.shift_kind   = ir[23:22];
          r.shift_amount = ir[15:10];
          r.alu_op       = ALU_ADD;
          r.dest_sel     = DEST_INT;
          r.dest_index   = rd;
        end else begin
          unimp = 1'b1;
        end
      end
      GRP_FP_A, GRP_FP_B: begin
        r.b_sel      = B_FP32;
        r.dest_sel   = DEST_FP;
        r.dest_index = rd;
        if (!single) begin
          unimp = 1'b1;
        end else if ((ir & FNEG_MASK) == OP_FNEG) begin
          // negate as zero minus the register
          r.a_sel   = A_ZERO;
          r.b_index = rn;
          r.alu_op  = ALU_FSUB;
        end else begin
          r.a_sel   = A_FP32;
          r.a_index = rn;
          r.b_index = rm;
          case (ir & FP2_MASK)
            OP_FADD: r.alu_op = ALU_FADD;
            OP_FSUB: r.alu_op = ALU_FSUB;
            OP_FMUL: r.alu_op = ALU_FMUL;
            OP_FDIV: r.alu_op = ALU_FDIV;
            default: unimp = 1'b1;
          endcase
        end
      end
      GRP_LS_A, GRP_LS_B, GRP_LS_C, GRP_LS_D: begin
        r.a_sel      = (rn == REG_ZR_SP) ? A_SP : A_INT64;
        r.a_index    = rn;
        r.dest_index = rd;
        case (ir & TOP10_MASK)
          OP_LDRSW_UIMM, OP_LDR_UIMM, OP_STR_UIMM: begin
            r.immediate = {14'd0, imm12, 2'd0};
            if ((ir & TOP10_MASK) == OP_STR_UIMM) begin
              r.mem_op = MEM_WR32;
            end else begin
              r.mem_op   = ((ir & TOP10_MASK) == OP_LDRSW_UIMM) ? MEM_RD32S : MEM_RD32;
              r.dest_sel = DEST_INT;
            end
          end
          default: begin
            if ((ir & LDRR_MASK) == OP_LDR_REG) begin
              r.b_sel    = B_REGX4;
              r.b_index  = rm;
              r.mem_op   = MEM_RD32;
              r.dest_sel = DEST_INT;
            end else begin
              unimp = 1'b1;
            end
          end
        endcase
      end
      GRP_BR_A, GRP_BR_B: begin
        if ((ir & B_MASK) == OP_B) begin
          r.a_sel     = A_PC;
          r.immediate = {ir[25:0], 2'd0};
          r.dest_sel  = DEST_PC;
        end else if ((ir & BCOND_MASK) == OP_BCOND) begin
          if (ir[3:0] != COND_LE) begin
            unimp = 1'b1;
          end else begin
            r.a_sel     = A_PC;
            r.immediate = {{7{off19[18]}}, off19, 2'd0};
            // taken when Z set or N differs from V
            r.dest_sel  = (it.flag_z || it.flag_n != it.flag_v) ? DEST_PC : DEST_NONE;
          end
        end else if ((ir & RET_MASK) == OP_RET) begin
          r.a_sel    = A_INT64;
          r.a_index  = rn;
          r.dest_sel = DEST_PC;
        end else begin
          unimp = 1'b1;
        end
      end
      default: unimp = 1'b1;
    endcase
    if (unimp) begin
      r        = '0;
      r.status = STATUS_UNIMP;
    end
    return r;
  endfunction

  // Random encoding based on one supported instruction, fields drawn at random (may hit unsupported variants).
  function automatic logic [31:0] wellformed_instr();
    logic [31:0] r;
    logic [31:0] ir;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: ir = OP_SUB_IMM64 | (r & ~TOP9_MASK);
      1: ir = OP_CMP_IMM32 | (r & ~TOP9_MASK);
      2: begin
        ir = OP_ADD_SR32 | (r & ~ADD_MASK);
        if ($urandom_range(0, 3) != 0) ir[15] = 1'b0;
      end
      3: begin
        case ($urandom_range(0, 3))
          0: ir = OP_FADD;
          1: ir = OP_FSUB;
          2: ir = OP_FMUL;
          default: ir = OP_FDIV;
        endcase
        ir |= r & ~FP2_MASK;
        if ($urandom_range(0, 3) != 0) ir[23:22] = 2'b00;
      end
      4: begin
        ir = OP_FNEG | (r & ~FNEG_MASK);
        if ($urandom_range(0, 3) != 0) ir[23:22] = 2'b00;
      end
      5: begin
        case ($urandom_range(0, 2))
          0: ir = OP_LDRSW_UIMM;
          1: ir = OP_LDR_UIMM;
          default: ir = OP_STR_UIMM;
        endcase
        ir |= r & ~TOP10_MASK;
      end
      6: ir = OP_LDR_REG | (r & ~LDRR_MASK);
      7: ir = OP_B | (r & ~B_MASK);
      8: begin
        ir = OP_BCOND | (r & ~BCOND_MASK);
        if ($urandom_range(0, 3) != 0) ir[3:0] = COND_LE;
      end
      default: ir = OP_RET | (r & ~RET_MASK);
    endcase
    return ir;
  endfunction

  task automatic queue_instr(logic [31:0] ir, logic n, logic z, logic v);
    in_item_t it;
    it.instr  = ir;
    it.flag_n = n;
    it.flag_z = z;
    it.flag_v = v;
    instr_q.push_back(it);
  endtask

  // Mostly well-formed words, some with one bit flipped, some pure noise.
  task automatic queue_random(int count);
    logic [31:0] ir;
    logic [2:0]  flags;
    int          pick;
    logic [4:0]  bit_idx;
    for (int i = 0; i < count; i++) begin
      pick    = $urandom_range(0, 13);
      ir      = wellformed_instr();
      bit_idx = 5'($urandom_range(0, 31));
      if (pick >= 12) begin
        ir = $urandom;
      end else if (pick >= 10) begin
        ir[bit_idx] = ~ir[bit_idx];
      end
      flags = 3'($urandom_range(0, 7));
      queue_instr(ir, flags[2], flags[1], flags[0]);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      err_count++;
    end
  endtask

  task automatic compare_decode(out_item_t want, out_item_t got);
    check_field("status", 32'(want.status), 32'(got.status));
    check_field("a_sel", 32'(want.a_sel), 32'(got.a_sel));
    check_field("a_index", 32'(want.a_index), 32'(got.a_index));
    check_field("b_sel", 32'(want.b_sel), 32'(got.b_sel));
    check_field("b_index", 32'(want.b_index), 32'(got.b_index));
    check_field("immediate", 32'(want.immediate), 32'(got.immediate));
    check_field("shift_kind", 32'(want.shift_kind), 32'(got.shift_kind));
    check_field("shift_amount", 32'(want.shift_amount), 32'(got.shift_amount));
    check_field("alu_op", 32'(want.alu_op), 32'(got.alu_op));
    check_field("mem_op", 32'(want.mem_op), 32'(got.mem_op));
    check_field("dest_sel", 32'(want.dest_sel), 32'(got.dest_sel));
    check_field("dest_index", 32'(want.dest_index), 32'(got.dest_index));
  endtask

  // Driver: predict each accepted transaction, then offer the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) decoded_q.push_back(predict_decode(in_data));
      if (!in_valid || in_ready) begin
        if (instr_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= instr_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check results in order and drive out_ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual %h", $time, out_data);
          err_count++;
        end else begin
          compare_decode(decoded_q.pop_front(), out_data);
        end
        result_count <= result_count + 1;
      end
      // one long hold-off so the pipe fills and backs up into in_ready
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (result_count == HOLD_AT_RESULT && !hold_done) begin
        out_ready <= 1'b0;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    // sub, cmp
    queue_instr(OP_SUB_IMM64 | 32'h003F_FFFF, 1'b0, 1'b0, 1'b0);
    queue_instr(OP_SUB_IMM64 | 32'h0040_0421, 1'b0, 1'b0, 1'b0);
    queue_instr(OP_CMP_IMM32 | 32'h007F_FFFF, 1'b1, 1'b1, 1'b1);
    queue_instr(OP_CMP_IMM32 | 32'h0000_045F, 1'b0, 1'b0, 1'b0);
    // add shifted register: plain, ASR by 31, reserved shift, shift too far
    queue_instr(OP_ADD_SR32 | 32'h0003_0041, 1'b0, 1'b0, 1'b0);
    queue_instr(OP_ADD_SR32 | 32'h009F_7FFF, 1'b0, 1'b0, 1'b0);
    queue_instr(OP_ADD_SR32 | 32'h00C0_0000, 1'b0, 1'b0, 1'b0);
    queue_instr(OP_ADD_SR32 | 32'h0000_8000, 1'b0, 1'b0, 1'b0);
    // fp single, one double, negate
    queue_instr(OP_FADD | 32'h001F_03FF, 1'b0, 1'b0, 1'b0);
    queue_instr(OP_FSUB | 32'h0005_0083, 1'b0, 1'b0, 1'b0);
    queue_instr(OP_FMUL | 32'h0005_0083, 1'b0, 1'b0, 1'b0);
    queue_instr(OP_FDIV | 32'h0005_0083, 1'b0, 1'b0, 1'b0);
    queue_instr(OP_FADD | 32'h0040_0000, 1'b0, 1'b0, 1'b0);
    queue_instr(OP_FNEG | 32'h0000_03E0, 1'b0, 1'b0, 1'b0);
    // loads and stores
    queue_instr(OP_LDRSW_UIMM | 32'h003F_FFE0, 1'b0, 1'b0, 1'b0);
    queue_instr(OP_LDR_UIMM | 32'h0000_0422, 1'b0, 1'b0, 1'b0);
    queue_instr(OP_STR_UIMM | 32'h0000_0BFF, 1'b0, 1'b0, 1'b0);
    queue_instr(OP_LDR_REG | 32'h001F_0041, 1'b0, 1'b0, 1'b0);
    // branches: offset extremes, LE taken and not taken
    queue_instr(OP_B | 32'h01FF_FFFF, 1'b0, 1'b0, 1'b0);
    queue_instr(OP_B | 32'h0200_0000, 1'b0, 1'b0, 1'b0);
    queue_instr(OP_BCOND | 32'h007F_FFE0 | 32'(COND_LE), 1'b0, 1'b0, 1'b0);
    queue_instr(OP_BCOND | 32'h0080_0000 | 32'(COND_LE), 1'b0, 1'b1, 1'b0);
    queue_instr(OP_BCOND | 32'h0000_0020 | 32'(COND_LE), 1'b1, 1'b0, 1'b0);
    queue_instr(OP_BCOND | 32'h0000_0020 | 32'(COND_LE), 1'b1, 1'b0, 1'b1);
    // EQ condition is not supported
    queue_instr(OP_BCOND | 32'h0000_0020, 1'b0, 1'b1, 1'b0);
    queue_instr(OP_RET | 32'h0000_03C0, 1'b0, 1'b0, 1'b0);
    queue_instr(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);

    // no idling, with the long receiver hold-off
    queue_random(RANDOM_PER_PHASE);
    while (instr_q.size() != 0) @(negedge clk);
    send_idle_pct = 45;
    queue_random(RANDOM_PER_PHASE);
    while (instr_q.size() != 0) @(negedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 45;
    queue_random(RANDOM_PER_PHASE);
    while (instr_q.size() != 0) @(negedge clk);
    send_idle_pct  = 17;
    recv_stall_pct = 17;
    queue_random(RANDOM_PER_PHASE);

    while (instr_q.size() != 0 || in_valid) @(negedge clk);
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
